/* rtl/pskytex_pkg.sv */
package pskytex_pkg;

	typedef struct packed {
		logic [2:0] face;
		logic [7:0] texel_x;
		logic [7:0] texel_y;
	} texel_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// register map
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;
	localparam logic [CFG_IDX_W-1:0] CFG_FACE_SIZE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROUGHNESS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SKY_COLOR    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GROUND_COLOR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_INTENSITY    = 3'd4;

	localparam logic [8:0]  RST_FACE_SIZE = 9'd64;
	localparam logic [15:0] RST_ROUGHNESS = 16'd32768;
	localparam logic [15:0] RST_INTENSITY = 16'd256;

	localparam logic [2:0] FACE_POS_Y = 3'd2;
	localparam logic [2:0] FACE_NEG_Y = 3'd3;

	// Q16 constants
	localparam int ONE_Q16   = 65536;
	localparam int HALF_Q16  = 32768;
	localparam int SS_E0_MAG = 11796;
	localparam int SS_W      = 62915;
	localparam int SS_HALF   = SS_W / 2;
	localparam int HB_K      = 29491;
	localparam int HZ_K      = 79954;
	localparam int KS_A      = 88474;
	localparam int KS_B      = 34734;
	localparam int KG_A      = 73400;
	localparam int KG_B      = 13107;
	localparam int ROUGH_ONE = 32768;

	// ceil(2^48 / SS_W): exact floor division by SS_W for dividends below 2^32
	localparam logic [32:0] SS_RCP   = 33'(((64'd1 << 48) + 64'(SS_W) - 64'd1) / 64'(SS_W));
	localparam logic [47:0] SS_RCP_C = 48'(64'(SS_HALF) * 64'(SS_RCP));

	// datapath widths
	localparam int CH_N   = 3;
	localparam int CH_W   = 16;
	localparam int Q_W    = 17;
	localparam int SCI_W  = 31;
	localparam int SV_W   = 36;
	localparam int HZ_W   = 37;
	localparam int HB_W   = 15;
	localparam int COL_W  = 25;

endpackage

/* rtl/procedural_sky_cube_texel.sv */
// Procedural sky cube texel generator.
// Texel channel (texel_valid/texel_ready, word texel): one cube face texel per
// word. Color channel (color_valid/color_ready, word color): its RGB8 value.
// Configuration: cfg_write with cfg_index/cfg_data writes one register at once;
// write only while no texel is in flight. A texel may follow on the next cycle.
// Throughput: one texel per cycle while texel_ready is high, fully pipelined.
// Pipeline: stages s1..s3, then SQ_ST = ceil((clog2(MAX_FACE_SIZE+1)+17)/4)
// square-root stages (4 root bits each), DV_ST = 6 divider stages (3 quotient
// bits each), stages s4..s9 and the output register, from texel accept to
// color_valid.
// Reset clears all valid bits and loads the register reset values; the
// pipeline holds no texel afterward.
// When color_ready is low the output word holds and the next word parks in a
// skid register; then texel_ready drops and the pipeline freezes until the
// skid drains. Nothing is lost or repeated.
module procedural_sky_cube_texel
	import pskytex_pkg::*;
#(
	parameter int MAX_FACE_SIZE = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  texel_valid,
	output logic                  texel_ready,
	input  texel_t                texel,
	output logic                  color_valid,
	input  logic                  color_ready,
	output rgb_t                  color,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int FS_W   = $clog2(MAX_FACE_SIZE + 1);
	localparam int CW     = (FS_W > 8) ? FS_W : 8;
	localparam int LEN_W  = 2 * FS_W + 2;
	localparam int RT_W   = LEN_W / 2 + 16;
	localparam int RM_W   = RT_W + 2;
	localparam int SQ_SPS = 4;
	localparam int SQ_ST  = (RT_W + SQ_SPS - 1) / SQ_SPS;
	localparam int DR_W   = RT_W + Q_W;
	localparam int DV_SPS = 3;
	localparam int DV_ST  = (Q_W + DV_SPS - 1) / DV_SPS;

	typedef struct packed {
		logic [RM_W-1:0]  rem;
		logic [RT_W-1:0]  root;
		logic [LEN_W-1:0] len2;
		logic [FS_W-1:0]  ay;
		logic             yneg;
	} sq_t;

	typedef struct packed {
		logic [DR_W-1:0] rem;
		logic [Q_W-1:0]  quo;
		logic [RT_W-1:0] dvs;
		logic            yneg;
	} dv_t;

	// ---------------- configuration ----------------
	logic [8:0]         face_size_q;
	logic [15:0]        roughness_q;
	logic [47:0]        sky_q;
	logic [47:0]        ground_q;
	logic signed [15:0] intensity_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_size_q <= RST_FACE_SIZE;
			roughness_q <= RST_ROUGHNESS;
			sky_q       <= '0;
			ground_q    <= '0;
			intensity_q <= RST_INTENSITY;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_FACE_SIZE:    face_size_q <= cfg_data[8:0];
				CFG_ROUGHNESS:    roughness_q <= cfg_data[15:0];
				CFG_SKY_COLOR:    sky_q       <= cfg_data;
				CFG_GROUND_COLOR: ground_q    <= cfg_data;
				CFG_INTENSITY:    intensity_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Color scale terms depend on registers only; they settle in the ks/kg,
	// sci/gci, sv/gv, hz registers after a write, well before the blend stages.
	logic [Q_W-1:0]   ks_q, kg_q;
	logic [SCI_W-1:0] sci_q [CH_N];
	logic [SCI_W-1:0] gci_q [CH_N];
	logic [SV_W-1:0]  sv_q  [CH_N];
	logic [SV_W-1:0]  gv_q  [CH_N];
	logic [HZ_W-1:0]  hz_q  [CH_N];

	always_ff @(posedge clk) begin
		logic [15:0] r;
		logic [14:0] inten;
		logic [31:0] ksm, kgm;
		logic [47:0] sp, gp;
		logic [HZ_W-1:0] sum;
		logic [54:0] hp;
		r     = (roughness_q > 16'(ROUGH_ONE)) ? 16'(ROUGH_ONE) : roughness_q;
		inten = intensity_q[15] ? '0 : intensity_q[14:0];
		ksm   = 32'(r) * 32'(KS_B) + 32'(16384);
		kgm   = 32'(r) * 32'(KG_B) + 32'(16384);
		ks_q  <= Q_W'(KS_A) - Q_W'(ksm >> 15);
		kg_q  <= Q_W'(KG_A) - Q_W'(kgm >> 15);
		for (int c = 0; c < CH_N; c++) begin
			sci_q[c] <= SCI_W'(sky_q[CH_W*c +: CH_W]) * SCI_W'(inten);
			gci_q[c] <= SCI_W'(ground_q[CH_W*c +: CH_W]) * SCI_W'(inten);
			sp = 48'(sci_q[c]) * 48'(ks_q) + 48'(2048);
			gp = 48'(gci_q[c]) * 48'(kg_q) + 48'(2048);
			sv_q[c] <= sp[47:12];
			gv_q[c] <= gp[47:12];
			sum = HZ_W'(sv_q[c]) + HZ_W'(gv_q[c]);
			hp  = 55'(sum) * 55'(HZ_K) + 55'(65536);
			hz_q[c] <= hp[53:17];
		end
	end

	// ---------------- stall control ----------------
	logic adv;
	logic color_v_q, skid_v_q;
	rgb_t color_q, skid_q;

	assign adv         = !skid_v_q;
	assign texel_ready = adv;

	// ---------------- s1: clamp, direction ----------------
	logic [FS_W-1:0] fs;
	logic [FS_W-1:0] am_s1, bm_s1, fs_s1, ay_s1;
	logic            yneg_s1, v_s1;

	always_comb begin
		if (face_size_q == '0) begin
			fs = FS_W'(1);
		end else if (32'(face_size_q) > 32'(MAX_FACE_SIZE)) begin
			fs = FS_W'(MAX_FACE_SIZE);
		end else begin
			fs = FS_W'(face_size_q);
		end
	end

	always_ff @(posedge clk) begin
		logic [FS_W-1:0] fsm1, x, y, bm;
		logic [FS_W:0]   ax2, by2, fse;
		if (adv) begin
			fsm1 = fs - FS_W'(1);
			x = (CW'(texel.texel_x) > CW'(fsm1)) ? fsm1 : FS_W'(texel.texel_x);
			y = (CW'(texel.texel_y) > CW'(fsm1)) ? fsm1 : FS_W'(texel.texel_y);
			ax2 = {x, 1'b1};
			by2 = {y, 1'b1};
			fse = {1'b0, fs};
			am_s1 <= (ax2 >= fse) ? FS_W'(ax2 - fse) : FS_W'(fse - ax2);
			bm    = (by2 >= fse) ? FS_W'(by2 - fse) : FS_W'(fse - by2);
			bm_s1 <= bm;
			fs_s1 <= fs;
			unique case (texel.face)
				FACE_POS_Y: begin
					ay_s1   <= fs;
					yneg_s1 <= 1'b0;
				end
				FACE_NEG_Y: begin
					ay_s1   <= fs;
					yneg_s1 <= 1'b1;
				end
				default: begin
					// vertical axis is -b on the side faces
					ay_s1   <= bm;
					yneg_s1 <= (by2 > fse);
				end
			endcase
		end
	end

	// ---------------- s2: squares, s3: squared length ----------------
	logic [2*FS_W-1:0] a2_s2, b2_s2, f2_s2;
	logic [FS_W-1:0]   ay_s2, ay_s3;
	logic              yneg_s2, yneg_s3, v_s2, v_s3;
	logic [LEN_W-1:0]  len2_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			a2_s2   <= (2*FS_W)'(am_s1) * (2*FS_W)'(am_s1);
			b2_s2   <= (2*FS_W)'(bm_s1) * (2*FS_W)'(bm_s1);
			f2_s2   <= (2*FS_W)'(fs_s1) * (2*FS_W)'(fs_s1);
			ay_s2   <= ay_s1;
			yneg_s2 <= yneg_s1;
			len2_s3 <= LEN_W'(a2_s2) + LEN_W'(b2_s2) + LEN_W'(f2_s2);
			ay_s3   <= ay_s2;
			yneg_s3 <= yneg_s2;
		end
	end

	// ---------------- square root of len2 * 2^32 ----------------
	sq_t  sq_in;
	sq_t  sq_s  [SQ_ST];
	logic sqv_s [SQ_ST];

	always_comb begin
		sq_in      = '0;
		sq_in.len2 = len2_s3;
		sq_in.ay   = ay_s3;
		sq_in.yneg = yneg_s3;
	end

	for (genvar g = 0; g < SQ_ST; g++) begin : g_sqrt
		sq_t  src, nxt;
		logic src_v;
		if (g == 0) begin : g_first
			assign src   = sq_in;
			assign src_v = v_s3;
		end else begin : g_next
			assign src   = sq_s[g-1];
			assign src_v = sqv_s[g-1];
		end

		always_comb begin
			logic [RM_W+1:0]  tmp, trial;
			logic [LEN_W-1:0] sh;
			int j;
			nxt = src;
			for (int k = 0; k < SQ_SPS; k++) begin
				j = g * SQ_SPS + k;
				if (j < RT_W) begin
					// low 32 bits of the radicand are zero
					sh    = nxt.len2 << (2 * j);
					tmp   = {nxt.rem, sh[LEN_W-1 -: 2]};
					trial = (RM_W+2)'({nxt.root, 2'b01});
					if (tmp >= trial) begin
						nxt.rem  = RM_W'(tmp - trial);
						nxt.root = {nxt.root[RT_W-2:0], 1'b1};
					end else begin
						nxt.rem  = RM_W'(tmp);
						nxt.root = {nxt.root[RT_W-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sqv_s[g] <= 1'b0;
			end else if (adv) begin
				sqv_s[g] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_s[g] <= nxt;
			end
		end
	end

	// ---------------- |dy| = round(ay * 2^32 / s) ----------------
	dv_t  dv_in;
	dv_t  dv_s  [DV_ST];
	logic dvv_s [DV_ST];

	always_comb begin
		dv_in.rem  = DR_W'({sq_s[SQ_ST-1].ay, 32'b0}) + DR_W'(sq_s[SQ_ST-1].root >> 1);
		dv_in.quo  = '0;
		dv_in.dvs  = sq_s[SQ_ST-1].root;
		dv_in.yneg = sq_s[SQ_ST-1].yneg;
	end

	for (genvar g = 0; g < DV_ST; g++) begin : g_div
		dv_t  src, nxt;
		logic src_v;
		if (g == 0) begin : g_first
			assign src   = dv_in;
			assign src_v = sqv_s[SQ_ST-1];
		end else begin : g_next
			assign src   = dv_s[g-1];
			assign src_v = dvv_s[g-1];
		end

		always_comb begin
			logic [DR_W-1:0] dsh;
			int j, k;
			nxt = src;
			for (int n = 0; n < DV_SPS; n++) begin
				j = g * DV_SPS + n;
				k = Q_W - 1 - j;
				if (j < Q_W) begin
					dsh = DR_W'(nxt.dvs) << k;
					if (nxt.rem >= dsh) begin
						nxt.rem    = nxt.rem - dsh;
						nxt.quo[k] = 1'b1;
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvv_s[g] <= 1'b0;
			end else if (adv) begin
				dvv_s[g] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[g] <= nxt;
			end
		end
	end

	// ---------------- s4: smoothstep offset, horizon square ----------------
	logic [CH_W-1:0] u_s4;
	logic [Q_W-1:0]  hw_s4;
	logic            tzero_s4, tsat_s4, v_s4;

	always_ff @(posedge clk) begin
		logic [Q_W-1:0] mag, u, h;
		logic [33:0]    hsq;
		if (adv) begin
			mag = (dv_s[DV_ST-1].quo > Q_W'(ONE_Q16)) ? Q_W'(ONE_Q16) : dv_s[DV_ST-1].quo;
			u   = dv_s[DV_ST-1].yneg ? Q_W'(SS_E0_MAG) - mag : Q_W'(SS_E0_MAG) + mag;
			h   = Q_W'(ONE_Q16) - mag;
			hsq = 34'(h) * 34'(h) + 34'(HALF_Q16);
			tzero_s4 <= dv_s[DV_ST-1].yneg && (mag >= Q_W'(SS_E0_MAG));
			// an offset of a full width or more gives t at 1.0
			tsat_s4  <= (u >= Q_W'(SS_W));
			u_s4     <= u[CH_W-1:0];
			hw_s4    <= hsq[32:16];
		end
	end

	// ---------------- s5: (u * 2^16 + SS_W/2) times reciprocal of SS_W ----------------
	logic [48:0]    rp_s5;
	logic [Q_W-1:0] hw_s5;
	logic           tzero_s5, tsat_s5, v_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			rp_s5    <= 49'(u_s4) * 49'(SS_RCP);
			hw_s5    <= hw_s4;
			tzero_s5 <= tzero_s4;
			tsat_s5  <= tsat_s4;
		end
	end

	// ---------------- s6..s9: weights, blends ----------------
	logic [Q_W-1:0]   t_s6, sw_s7;
	logic [32:0]      tt_s6;
	logic [HB_W-1:0]  hb_s6, hb_s7, hb_s8;
	logic [SV_W-1:0]  base_s8 [CH_N];
	logic [COL_W-1:0] col_s9  [CH_N];
	logic             v_s6, v_s7, v_s8, v_s9;

	always_ff @(posedge clk) begin
		logic [Q_W-1:0]  t;
		logic [64:0]     qp;
		logic [32:0]     hbp;
		logic [17:0]     wt;
		logic [51:0]     swp;
		logic [Q_W-1:0]  wg, wb;
		logic [53:0]     bp;
		logic [54:0]     cp;
		logic [38:0]     full;
		if (adv) begin
			// s6: quotient is the top bits of the scaled product
			qp = {rp_s5, 16'b0} + 65'(SS_RCP_C);
			if (tzero_s5) begin
				t = '0;
			end else if (tsat_s5) begin
				t = Q_W'(ONE_Q16);
			end else begin
				t = qp[64:48];
			end
			hbp   = 33'(hw_s5) * 33'(HB_K) + 33'(HALF_Q16);
			t_s6  <= t;
			tt_s6 <= 33'(t) * 33'(t);
			hb_s6 <= hbp[30:16];
			// s7: 3t^2 - 2t^3
			wt    = 18'(3 * ONE_Q16) - 18'({t_s6, 1'b0});
			swp   = 52'(tt_s6) * 52'(wt) + 52'(33'h0_8000_0000);
			sw_s7 <= swp[48:32];
			hb_s7 <= hb_s6;
			// s8: ground to sky
			wg    = Q_W'(ONE_Q16) - sw_s7;
			hb_s8 <= hb_s7;
			for (int c = 0; c < CH_N; c++) begin
				bp = 54'(gv_q[c]) * 54'(wg) + 54'(sv_q[c]) * 54'(sw_s7) + 54'(HALF_Q16);
				base_s8[c] <= bp[51:16];
			end
			// s9: horizon band, clamp to 1.0
			wb = Q_W'(ONE_Q16) - Q_W'(hb_s8);
			for (int c = 0; c < CH_N; c++) begin
				cp   = 55'(base_s8[c]) * 55'(wb) + 55'(hz_q[c]) * 55'(hb_s8) + 55'(HALF_Q16);
				full = cp[54:16];
				col_s9[c] <= (full > 39'(1 << 24)) ? COL_W'(1 << 24) : full[COL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (adv) begin
			v_s1 <= texel_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= dvv_s[DV_ST-1];
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// ---------------- 8-bit rounding, output and skid ----------------
	rgb_t rgb;
	logic out_fire;

	always_comb begin
		logic [32:0] p [CH_N];
		for (int c = 0; c < CH_N; c++) begin
			p[c] = 33'(col_s9[c]) * 33'(255) + 33'(1 << 23);
		end
		rgb.red   = p[0][31:24];
		rgb.green = p[1][31:24];
		rgb.blue  = p[2][31:24];
	end

	assign out_fire = color_v_q && color_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_v_q <= 1'b0;
			skid_v_q  <= 1'b0;
		end else if (adv && v_s9) begin
			if (!color_v_q || out_fire) begin
				color_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (out_fire) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				color_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s9) begin
			if (!color_v_q || out_fire) begin
				color_q <= rgb;
			end else begin
				skid_q <= rgb;
			end
		end else if (out_fire && skid_v_q) begin
			color_q <= skid_q;
		end
	end

	assign color_valid = color_v_q;
	assign color       = color_q;

endmodule

/* dv/procedural_sky_cube_texel_test.sv */
`timescale 1ns / 100ps

module procedural_sky_cube_texel_test;
	import pskytex_pkg::*;

	localparam int MAX_FS = 256;
	localparam int LATENCY = 23;
	localparam int N_RANDOM = 1800;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk = 0;
	logic arst_n = 0;
	logic texel_valid = 0;
	logic texel_ready;
	texel_t texel = '0;
	logic color_valid;
	logic color_ready = 0;
	rgb_t color;
	logic cfg_write = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	procedural_sky_cube_texel #(.MAX_FACE_SIZE(MAX_FS)) uut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// shadow registers
	logic [8:0] fs_reg;
	logic [15:0] rough_reg;
	logic [47:0] sky_reg, ground_reg;
	logic signed [15:0] inten_reg;

	rgb_t color_q[$];
	int mismatches = 0;
	int unexpected = 0;
	longint cycles = 0;
	bit no_idle = 0;

	function automatic longint unsigned root64(longint unsigned n);
		longint unsigned r, bitv;
		r = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= r + bitv) begin
				n -= r + bitv;
				r = (r >> 1) + bitv;
			end else begin
				r >>= 1;
			end
			bitv >>= 2;
		end
		return r;
	endfunction

	function automatic rgb_t sky_shade(texel_t t);
		longint fs, x, y, a, b, yc, ay, d, rr;
		longint unsigned len2, s, mag, tw, sw, h, hw, hb, ks, kg, inten;
		longint unsigned sc, gc, sv, gv, base, hz, col;
		logic [7:0] ch[3];
		rgb_t res;
		fs = fs_reg;
		if (fs < 1) fs = 1;
		if (fs > MAX_FS) fs = MAX_FS;
		x = t.texel_x;
		y = t.texel_y;
		if (x > fs - 1) x = fs - 1;
		if (y > fs - 1) y = fs - 1;
		a = 2 * x + 1 - fs;
		b = 2 * y + 1 - fs;
		if (t.face == FACE_POS_Y) yc = fs;
		else if (t.face == FACE_NEG_Y) yc = -fs;
		else yc = -b;
		len2 = fs * fs + a * a + b * b;
		s = root64(len2 << 32);
		if (s == 0) s = 1;
		ay = yc < 0 ? -yc : yc;
		mag = ((longint'(ay) << 32) + s / 2) / s;
		if (mag > ONE_Q16) mag = ONE_Q16;
		d = yc < 0 ? -longint'(mag) : longint'(mag);
		if (d <= -SS_E0_MAG) tw = 0;
		else begin
			tw = ((d + SS_E0_MAG) * 65536 + SS_HALF) / SS_W;
			if (tw > ONE_Q16) tw = ONE_Q16;
		end
		sw = (tw * tw * (3 * 65536 - 2 * tw) + (64'd1 << 31)) >> 32;
		h = ONE_Q16 - mag;
		hw = (h * h + 32768) >> 16;
		hb = (hw * HB_K + 32768) >> 16;
		rr = rough_reg > ROUGH_ONE ? ROUGH_ONE : rough_reg;
		ks = KS_A - ((KS_B * rr + 16384) >> 15);
		kg = KG_A - ((KG_B * rr + 16384) >> 15);
		inten = inten_reg < 0 ? 0 : inten_reg;
		for (int c = 0; c < 3; c++) begin
			sc = (sky_reg >> (16 * c)) & 16'hFFFF;
			gc = (ground_reg >> (16 * c)) & 16'hFFFF;
			sv = (sc * inten * ks + 2048) >> 12;
			gv = (gc * inten * kg + 2048) >> 12;
			base = (gv * (65536 - sw) + sv * sw + 32768) >> 16;
			hz = ((gv + sv) * HZ_K + 65536) >> 17;
			col = (base * (65536 - hb) + hz * hb + 32768) >> 16;
			if (col > (64'd1 << 24)) col = 64'd1 << 24;
			ch[c] = 8'((col * 255 + (64'd1 << 23)) >> 24);
		end
		res.red = ch[0];
		res.green = ch[1];
		res.blue = ch[2];
		return res;
	endfunction

	// color side: random backpressure bursts, checker
	int stall_left = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n) begin
			if (color_valid && color_ready) begin
				if (color_q.size() == 0) begin
					unexpected++;
					if (mismatches + unexpected <= 10)
						$display("unexpected color word %h", color);
				end else begin
					rgb_t ex;
					ex = color_q.pop_front();
					if (ex !== color) begin
						mismatches++;
						if (mismatches <= 10)
							$display("color mismatch: expected r%0d g%0d b%0d, got r%0d g%0d b%0d",
								ex.red, ex.green, ex.blue, color.red, color.green, color.blue);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				color_ready <= 0;
			end else if (!no_idle && $urandom_range(0, 9) == 0) begin
				stall_left <= $urandom_range(0, 2);
				color_ready <= 0;
			end else begin
				color_ready <= 1;
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic cfg_put(logic [CFG_IDX_W-1:0] idx, logic [47:0] val);
		cfg_write <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 0;
		case (idx)
			CFG_FACE_SIZE: fs_reg = val[8:0];
			CFG_ROUGHNESS: rough_reg = val[15:0];
			CFG_SKY_COLOR: sky_reg = val;
			CFG_GROUND_COLOR: ground_reg = val;
			CFG_INTENSITY: inten_reg = val[15:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// send one texel word; expected color predicted at accept
	task automatic send_texel(texel_t t, bit gaps);
		if (gaps && !no_idle && $urandom_range(0, 7) == 0) begin
			texel_valid <= 0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		texel_valid <= 1;
		texel <= t;
		@(posedge clk);
		while (!texel_ready) @(posedge clk);
		color_q = {color_q, sky_shade(t)};
	endtask

	task automatic drain;
		texel_valid <= 0;
		while (color_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic texel_t rand_texel(int fs);
		texel_t t;
		t.face = $urandom_range(0, 9) == 0 ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
		if ($urandom_range(0, 7) == 0) begin
			t.texel_x = 8'($urandom);
			t.texel_y = 8'($urandom);
		end else begin
			t.texel_x = 8'($urandom_range(0, fs > 256 ? 255 : (fs < 1 ? 0 : fs - 1)));
			t.texel_y = 8'($urandom_range(0, fs > 256 ? 255 : (fs < 1 ? 0 : fs - 1)));
		end
		return t;
	endfunction

	function automatic logic [47:0] rand_color();
		logic [47:0] v;
		v = 48'({$urandom, $urandom});
		// mostly within 0..1 per channel so results are not all saturated
		if ($urandom_range(0, 2) != 0)
			for (int c = 0; c < 3; c++) v[16*c +: 16] = 16'($urandom_range(0, 4608));
		return v;
	endfunction

	typedef struct {
		texel_t t;
		bit known;
		rgb_t ex;
	} texel_row_t;

	texel_row_t dir_rows[] = '{
		'{'{3'd0, 8'd0, 8'd0}, 1, '0},        // all colors zero after reset
		'{'{3'd2, 8'd63, 8'd63}, 1, '0},
		'{'{3'd5, 8'd255, 8'd255}, 1, '0}
	};

	initial begin
		fs_reg = RST_FACE_SIZE;
		rough_reg = RST_ROUGHNESS;
		sky_reg = '0;
		ground_reg = '0;
		inten_reg = RST_INTENSITY;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send_texel(dir_rows[i].t, 0);
			if (dir_rows[i].known && sky_shade(dir_rows[i].t) !== dir_rows[i].ex) begin
				mismatches++;
				$display("directed row %0d: prediction disagrees with table", i);
			end
		end
		drain();

		// white sky, tinted ground, every face code, corner texels, extreme sizes
		cfg_put(CFG_SKY_COLOR, {3{16'd4096}});
		cfg_put(CFG_GROUND_COLOR, {16'd1000, 16'd2000, 16'd4096});
		for (int f = 0; f < 8; f++)
			send_texel('{3'(f), 8'd0, 8'd255}, 0);
		drain();
		cfg_put(CFG_FACE_SIZE, 9'd1);
		send_texel('{3'd0, 8'd255, 8'd255}, 0);
		send_texel('{3'd2, 8'd0, 8'd0}, 0);
		drain();
		cfg_put(CFG_FACE_SIZE, 9'd0);
		cfg_put(CFG_ROUGHNESS, 16'hFFFF);
		cfg_put(CFG_INTENSITY, 16'h8000);
		send_texel('{3'd4, 8'd0, 8'd0}, 0);
		drain();
		cfg_put(CFG_FACE_SIZE, 9'd511);
		cfg_put(CFG_ROUGHNESS, 16'd0);
		cfg_put(CFG_INTENSITY, 16'h7FFF);
		cfg_put(CFG_SKY_COLOR, 48'hFFFF_FFFF_FFFF);
		send_texel('{3'd1, 8'd255, 8'd0}, 0);
		send_texel('{3'd3, 8'd128, 8'd128}, 0);
		drain();
		cfg_put(CFG_FACE_SIZE, 9'd256);
		cfg_put(CFG_INTENSITY, 16'd256);
		cfg_put(CFG_SKY_COLOR, {16'd100, 16'd2000, 16'd4000});
		send_texel('{3'd4, 8'd0, 8'd127}, 0);
		send_texel('{3'd4, 8'd255, 8'd200}, 0);
		send_texel('{3'd6, 8'd10, 8'd20}, 0);
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			int fs_pick;
			case (ph % 4)
				0: fs_pick = $urandom_range(1, 16);
				1: fs_pick = $urandom_range(1, 256);
				2: fs_pick = $urandom_range(0, 511);
				default: fs_pick = 256;
			endcase
			if (ph == 11) no_idle = 1;
			cfg_put(CFG_FACE_SIZE, 9'(fs_pick));
			cfg_put(CFG_ROUGHNESS, $urandom_range(0, 9) == 0 ? 16'($urandom)
				: 16'($urandom_range(0, 32768)));
			cfg_put(CFG_SKY_COLOR, rand_color());
			cfg_put(CFG_GROUND_COLOR, rand_color());
			cfg_put(CFG_INTENSITY, $urandom_range(0, 5) == 0 ? 16'($urandom)
				: 16'($urandom_range(128, 512)));
			for (int k = 0; k < N_RANDOM / 12; k++) begin
				send_texel(rand_texel(fs_pick), 1);
				// pause until the pipe is empty once
				if (ph == 3 && k == 40) begin
					texel_valid <= 0;
					while (color_q.size() != 0) @(posedge clk);
				end
			end
			drain();
		end

		if (mismatches == 0 && unexpected == 0 && color_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
